[sv/ordered_multiset_engine_assert.svh]
// Assertion macros for the ordered multiset engine.
// Used by the top level; no other dependencies.
`ifndef ORDERED_MULTISET_ENGINE_ASSERT_SVH
`define ORDERED_MULTISET_ENGINE_ASSERT_SVH
`ifndef ASSERT_OFF
`define OMS_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define OMS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define OMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define OMS_ASSERT(label, clk, rst_n, expr)
`define OMS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define OMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[sv/oms_pkg.sv]
// Shared types and constants for the ordered multiset engine.
// No dependencies.
package oms_pkg;
    localparam int CAPACITY_DEF = 256;
    localparam int KEY_BITS_DEF = 32;
    localparam int KEY_W = 32;
    localparam int OP_W = 3;
    localparam int ST_W = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_W-1:0] OP_PRED = 3'd2;
    localparam logic [OP_W-1:0] OP_SUCC = 3'd3;

    localparam logic [ST_W-1:0] ST_DONE = 2'd0;
    localparam logic [ST_W-1:0] ST_NONE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;
    localparam logic [ST_W-1:0] ST_UNSUP = 2'd3;

    typedef struct packed {
        logic load;
        logic cmp;
        logic exec;
    } oms_cmd_t;
endpackage

[sv/oms_ctrl.sv]
// Controller for the ordered multiset engine: sequencing and output handshake.
// Depends on oms_pkg.
module oms_ctrl
    import oms_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output oms_cmd_t cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        out_valid_next = out_valid_reg && !m_ready;
        cmd = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                cmd.cmp = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.exec = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

[sv/oms_datapath.sv]
// Datapath: sorted register cells with parallel compare, shift and select.
// Depends on oms_pkg.
module oms_datapath
    import oms_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  oms_cmd_t                       cmd,
    input  logic [OP_W-1:0]                s_operation,
    input  logic signed [KEY_W-1:0]        s_key,
    output logic [ST_W-1:0]                m_status,
    output logic signed [KEY_W-1:0]        m_found_key,
    output logic [$clog2(CAPACITY+1)-1:0]  count
);
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [KEY_BITS-1:0] cells_reg [CAPACITY];
    logic signed [KEY_BITS-1:0] cells_next [CAPACITY];
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic [OP_W-1:0]            op_reg;
    logic signed [KEY_BITS-1:0] k_reg, k_in;
    logic [CAPACITY-1:0]        lt_reg, eq_reg, gt_reg;
    logic [ST_W-1:0]            st_reg, st_next;
    logic signed [KEY_BITS-1:0] found_reg, found_next, pred_sel, succ_sel;
    logic                       full, hit_eq, hit_lt, hit_gt;

    generate
        if (KEY_BITS <= KEY_W) begin : g_in_narrow
            assign k_in = s_key[KEY_BITS-1:0];
            assign m_found_key = KEY_W'(found_reg);
        end else begin : g_in_wide
            assign k_in = KEY_BITS'(s_key);
            assign m_found_key = found_reg[KEY_W-1:0];
        end
    endgenerate

    assign count = cnt_reg;
    assign m_status = st_reg;
    assign full = (cnt_reg == CW'(CAPACITY));
    assign hit_eq = |eq_reg;
    assign hit_lt = |lt_reg;
    assign hit_gt = |gt_reg;

    always_comb begin
        pred_sel = '0;
        succ_sel = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (lt_reg[i] && (i == CAPACITY - 1 || !lt_reg[(i+1) % CAPACITY]))
                pred_sel = pred_sel | cells_reg[i];
            if (gt_reg[i] && (i == 0 || !gt_reg[(i+CAPACITY-1) % CAPACITY]))
                succ_sel = succ_sel | cells_reg[i];
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        st_next = ST_DONE;
        found_next = '0;
        for (int i = 0; i < CAPACITY; i++) cells_next[i] = cells_reg[i];
        unique case (op_reg)
            OP_INSERT: begin
                if (full) begin
                    st_next = ST_FULL;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (!(lt_reg[i] || eq_reg[i])) begin
                            if (i == 0)
                                cells_next[i] = k_reg;
                            else if (lt_reg[(i+CAPACITY-1) % CAPACITY] ||
                                     eq_reg[(i+CAPACITY-1) % CAPACITY])
                                cells_next[i] = k_reg;
                            else
                                cells_next[i] = cells_reg[(i+CAPACITY-1) % CAPACITY];
                        end
                    end
                end
            end
            OP_DELETE: begin
                if (!hit_eq) begin
                    st_next = ST_NONE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                    for (int i = 0; i < CAPACITY - 1; i++)
                        if (!lt_reg[i]) cells_next[i] = cells_reg[i+1];
                end
            end
            OP_PRED: begin
                if (hit_lt) found_next = pred_sel;
                else st_next = ST_NONE;
            end
            OP_SUCC: begin
                if (hit_gt) found_next = succ_sel;
                else st_next = ST_NONE;
            end
            default: st_next = ST_UNSUP;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.exec) begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= s_operation;
            k_reg <= k_in;
        end
        if (cmd.cmp) begin
            for (int i = 0; i < CAPACITY; i++) begin
                lt_reg[i] <= (CW'(i) < cnt_reg) && (cells_reg[i] < k_reg);
                eq_reg[i] <= (CW'(i) < cnt_reg) && (cells_reg[i] == k_reg);
                gt_reg[i] <= (CW'(i) < cnt_reg) && (cells_reg[i] > k_reg);
            end
        end
        if (cmd.exec) begin
            for (int i = 0; i < CAPACITY; i++) cells_reg[i] <= cells_next[i];
            st_reg <= st_next;
            found_reg <= found_next;
        end
    end
endmodule

[sv/ordered_multiset_engine.sv]
// Top level of the ordered multiset engine: controller plus cell datapath.
// Depends on oms_pkg, oms_ctrl, oms_datapath and the assertion header.
// Each item occupies the block until its result is registered. The accepting edge
// captures the request. Then every register cell compares its key with the request
// key into registered flags. Then the block selects the neighbor key or shifts the
// cells and registers the result together with the output valid. The next item can be
// taken in the cycle in which the result first shows. A stalled output holds the
// execute step until the pending result leaves. Keys stay sorted; duplicates take
// one cell each.
`include "ordered_multiset_engine_assert.svh"
module ordered_multiset_engine
    import oms_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [OP_W-1:0]         s_operation,
    input  logic signed [KEY_W-1:0] s_key,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [ST_W-1:0]         m_status,
    output logic signed [KEY_W-1:0] m_found_key
);
    oms_cmd_t                          cmd;
    logic [$clog2(CAPACITY+1)-1:0]     count;

    oms_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd)
    );

    oms_datapath #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .s_operation(s_operation),
        .s_key(s_key), .m_status(m_status), .m_found_key(m_found_key),
        .count(count)
    );

    `OMS_ASSERT(a_count_bound, aclk, aresetn, count <= ($clog2(CAPACITY+1))'(CAPACITY))
    `OMS_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `OMS_ASSERT_IMPL(a_found_zero, aclk, aresetn, m_valid && (m_status != ST_DONE), m_found_key == '0)
endmodule
